>>> src/var_record_sector_deframer_assert.svh
// Assertion macros for the file that checks this block.
`ifndef VAR_RECORD_SECTOR_DEFRAMER_ASSERT_SVH
`define VAR_RECORD_SECTOR_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VRSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication in the same cycle");

// Next-cycle implication, disabled during reset.
`define VRSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: implication in the next cycle");

`endif

>>> src/vrsd_pkg.sv
`timescale 1ns / 1ps

package vrsd_pkg;

   localparam int SECTOR_BYTES = 256;
   localparam int OFFSET_W     = $clog2(SECTOR_BYTES);
   localparam int LIMIT_W      = 24;
   localparam int SUM_W        = 10;

   localparam logic [7:0] LEN_MARK = 8'hFF;
   localparam logic [7:0] NEWLINE  = 8'd10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   // Bit positions of the pieces a single input item can produce, in output order.
   localparam int PIECE_CHAR = 0;
   localparam int PIECE_NL   = 1;
   localparam int PIECE_END  = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         text_char;
      logic               is_end;
      logic [LIMIT_W-1:0] text_length;
      logic               last_of_item;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]         pieces;
      logic [7:0]         record_char;
      logic [LIMIT_W-1:0] end_length;
   } group_type;

endpackage

>>> src/vrsd_parser.sv
`timescale 1ns / 1ps

module vrsd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [vrsd_pkg::LIMIT_W-1:0] csr_write_data,
   input  logic                         accept,
   input  vrsd_pkg::req_item_type       item,
   output logic                         group_valid,
   output vrsd_pkg::group_type          group
);

   localparam logic [1:0] MODE_LEN  = 2'd0;
   localparam logic [1:0] MODE_BODY = 2'd1;
   localparam logic [1:0] MODE_SKIP = 2'd2;

   localparam logic [vrsd_pkg::SUM_W-1:0] SECTOR_SUM = vrsd_pkg::SUM_W'(vrsd_pkg::SECTOR_BYTES);
   localparam logic [vrsd_pkg::OFFSET_W:0] SECTOR_WRAP =
      (vrsd_pkg::OFFSET_W+1)'(vrsd_pkg::SECTOR_BYTES);

   logic [vrsd_pkg::LIMIT_W-1:0]  limit_ff;
   logic [vrsd_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [7:0]                    record_ff, record_in;
   logic [7:0]                    copy_ff, copy_in;
   logic [vrsd_pkg::LIMIT_W-1:0]  emitted_ff, emitted_in;
   logic                          stopped_ff, stopped_in;

   logic [vrsd_pkg::LIMIT_W-1:0]  lim;
   logic [vrsd_pkg::LIMIT_W-1:0]  room;
   logic [vrsd_pkg::SUM_W-1:0]    end_pos;
   logic [vrsd_pkg::OFFSET_W:0]   offset_plus;
   logic [7:0]                    record_next;
   logic                          stop;
   logic                          has_char;
   logic                          has_nl;

   always_comb begin
      lim         = (limit_ff == '0) ? vrsd_pkg::LIMIT_W'(1) : limit_ff;
      room        = lim - emitted_ff - vrsd_pkg::LIMIT_W'(2);
      end_pos     = vrsd_pkg::SUM_W'(offset_ff) + vrsd_pkg::SUM_W'(item.data_byte)
                    + vrsd_pkg::SUM_W'(1);
      offset_plus = {1'b0, offset_ff} + (vrsd_pkg::OFFSET_W+1)'(1);
      record_next = (record_ff != 8'd0) ? record_ff - 8'd1 : 8'd0;
      stop        = stopped_ff || (emitted_ff >= lim - vrsd_pkg::LIMIT_W'(1));

      mode_in    = mode_ff;
      record_in  = record_ff;
      copy_in    = copy_ff;
      stopped_in = stopped_ff;
      has_char   = 1'b0;
      has_nl     = 1'b0;

      case (mode_ff)
         MODE_LEN: begin
            stopped_in = stop;
            if (stop) begin
               mode_in = MODE_SKIP;
            end else if ((item.data_byte == vrsd_pkg::LEN_MARK) || (end_pos > SECTOR_SUM)) begin
               mode_in = MODE_SKIP;
            end else begin
               copy_in   = (vrsd_pkg::LIMIT_W'(item.data_byte) < room) ? item.data_byte
                                                                        : room[7:0];
               record_in = item.data_byte;
               if (item.data_byte == 8'd0) begin
                  has_nl = 1'b1;
               end else begin
                  mode_in = MODE_BODY;
               end
            end
         end
         MODE_BODY: begin
            if (copy_ff != 8'd0) begin
               has_char = 1'b1;
               copy_in  = copy_ff - 8'd1;
            end
            record_in = record_next;
            if (record_next == 8'd0) begin
               has_nl  = 1'b1;
               copy_in = 8'd0;
               mode_in = MODE_LEN;
            end
         end
         default: begin
            mode_in = MODE_SKIP;
         end
      endcase

      emitted_in = emitted_ff + vrsd_pkg::LIMIT_W'(has_char) + vrsd_pkg::LIMIT_W'(has_nl);

      if (offset_plus >= SECTOR_WRAP) begin
         offset_in = '0;
         mode_in   = MODE_LEN;
         record_in = 8'd0;
         copy_in   = 8'd0;
      end else begin
         offset_in = offset_plus[vrsd_pkg::OFFSET_W-1:0];
      end

      group.pieces                       = 3'b000;
      group.pieces[vrsd_pkg::PIECE_CHAR] = has_char;
      group.pieces[vrsd_pkg::PIECE_NL]   = has_nl;
      group.pieces[vrsd_pkg::PIECE_END]  = item.end_of_data;
      group.record_char                  = item.data_byte;
      group.end_length                   = emitted_in;
      group_valid                        = |group.pieces;

      // The end of a file returns the stream state to its reset value.
      if (item.end_of_data) begin
         offset_in  = '0;
         mode_in    = MODE_LEN;
         record_in  = 8'd0;
         copy_in    = 8'd0;
         emitted_in = '0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= vrsd_pkg::LIMIT_RESET;
         offset_ff  <= '0;
         mode_ff    <= MODE_LEN;
         record_ff  <= 8'd0;
         copy_ff    <= 8'd0;
         emitted_ff <= '0;
         stopped_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (accept) begin
            offset_ff  <= offset_in;
            mode_ff    <= mode_in;
            record_ff  <= record_in;
            copy_ff    <= copy_in;
            emitted_ff <= emitted_in;
            stopped_ff <= stopped_in;
         end
      end
   end

endmodule

>>> src/vrsd_emitter.sv
`timescale 1ns / 1ps

module vrsd_emitter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vrsd_pkg::group_type     push_group,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output vrsd_pkg::rsp_item_type  rsp_item
);

   vrsd_pkg::group_type entry_ff [2];
   logic       head_ff;
   logic       tail_ff;
   logic [1:0] count_ff;

   vrsd_pkg::group_type head_group;
   logic [2:0] rest;
   logic       take;
   logic       retire;

   always_comb begin
      head_group = entry_ff[head_ff];
      rest       = head_group.pieces & (head_group.pieces - 3'b001);
      rsp_valid  = (count_ff != 2'd0);
      full       = (count_ff == 2'd2);
      take       = rsp_valid && !rsp_stall;
      retire     = take && (rest == 3'b000);

      rsp_item.last_of_item = (rest == 3'b000);
      rsp_item.is_end       = 1'b0;
      rsp_item.text_length  = '0;
      if (head_group.pieces[vrsd_pkg::PIECE_CHAR]) begin
         rsp_item.text_char = head_group.record_char;
      end else if (head_group.pieces[vrsd_pkg::PIECE_NL]) begin
         rsp_item.text_char = vrsd_pkg::NEWLINE;
      end else begin
         rsp_item.text_char   = 8'd0;
         rsp_item.is_end      = 1'b1;
         rsp_item.text_length = head_group.end_length;
      end
   end

   // Payload storage: the head entry loses its first piece as each result is taken.
   always_ff @(posedge clock) begin
      if (take && !retire) begin
         entry_ff[head_ff].pieces <= rest;
      end
      if (push) begin
         entry_ff[tail_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (retire) begin
            head_ff <= ~head_ff;
         end
         if (push) begin
            tail_ff <= ~tail_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(retire);
      end
   end

endmodule

>>> src/var_record_sector_deframer.sv
// Latency: results are buffered; an item's first is offered once older results are taken.
// Throughput: one item per cycle while each item yields at most one result and rsp_stall
// is low; results leave at one per cycle while rsp_stall is low, so an item with two or
// three results holds the input off once the two-entry result buffer is full.
// Reset: synchronous, active high; clears the parser and the buffer, limit to 16777215.
`timescale 1ns / 1ps

module var_record_sector_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [vrsd_pkg::LIMIT_W-1:0] csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  vrsd_pkg::req_item_type       req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output vrsd_pkg::rsp_item_type       rsp_item
);

`include "var_record_sector_deframer_assert.svh"

   // An item is accepted whenever the result buffer has a free entry. The parser
   // updates its stream state in that same cycle, so the next byte can follow at once.
   logic                accept;
   logic                group_valid;
   logic                buffer_full;
   vrsd_pkg::group_type group;

   assign req_stall = buffer_full;
   assign accept    = req_valid && !req_stall;

   // The parser holds the sector position, the record counters, the emitted count
   // and the output limit. It turns one byte into a group of up to three results:
   // a record byte, the newline closing a record, and the end result.
   vrsd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .item             (req_item),
      .group_valid      (group_valid),
      .group            (group)
   );

   // The emitter buffers up to two groups and hands their results out one at a time.
   // Bytes that produce nothing, such as skipped sector tails, never enter the buffer.
   vrsd_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && group_valid),
      .push_group (group),
      .full       (buffer_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // The end result always closes the group of its item.
   `VRSD_ASSERT_IMPLY(end_is_last, clock, reset, rsp_valid && rsp_item.is_end, rsp_item.last_of_item)
   // Character results carry no length.
   `VRSD_ASSERT_IMPLY(char_no_length, clock, reset, rsp_valid && !rsp_item.is_end, rsp_item.text_length == '0)
   // The last byte of a file always leaves a result waiting.
   `VRSD_ASSERT_NEXT(end_gives_result, clock, reset, accept && req_item.end_of_data, rsp_valid)
   // The input is only held off while results are waiting.
   `VRSD_ASSERT_IMPLY(stall_needs_output, clock, reset, req_stall, rsp_valid)

endmodule
